// ===== sv/cle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the console line editor
// Command codes, control characters, echo sequence table and result kinds.
// ----------------------------------------------------------------------------
package cle_pkg;

  // control characters recognized on the receive side
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_FF  = 8'h0C;

  // result kinds
  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_MARK    = 2'd2;

  // positions in the echo sequence table
  localparam int         SEQ_W         = 5;
  localparam logic [4:0] SEQ_FF_FIRST  = 5'd0;
  localparam logic [4:0] SEQ_FF_LAST   = 5'd9;
  localparam logic [4:0] SEQ_EOL_FIRST = 5'd10;
  localparam logic [4:0] SEQ_EOL_LAST  = 5'd15;
  localparam logic [4:0] SEQ_DEL_FIRST = 5'd16;
  localparam logic [4:0] SEQ_DEL_LAST  = 5'd18;

  // command classes handed from the front to the back
  typedef enum logic [1:0] {
    CMD_EOL,
    CMD_DEL,
    CMD_FF,
    CMD_APPEND
  } cmd_t;

  // one queued word: command class and the received byte
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } cmd_item_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_APP,
    BS_CONT,
    BS_MARK,
    BS_SEQ
  } back_state_t;

  // echo sequence table: clear/home/prompt, crlf/prompt, rubout
  function automatic logic [7:0] seq_byte(input logic [4:0] pos);
    logic [7:0] b;
    case (pos)
      5'd0:    b = 8'h1B;
      5'd1:    b = 8'h5B;
      5'd2:    b = 8'h32;
      5'd3:    b = 8'h4A;
      5'd4:    b = 8'h1B;
      5'd5:    b = 8'h5B;
      5'd6:    b = 8'h3B;
      5'd7:    b = 8'h48;
      5'd8:    b = 8'h3E;
      5'd9:    b = 8'h20;
      5'd10:   b = 8'h0D;
      5'd11:   b = 8'h0A;
      5'd12:   b = 8'h0D;
      5'd13:   b = 8'h0A;
      5'd14:   b = 8'h3E;
      5'd15:   b = 8'h20;
      5'd16:   b = 8'h08;
      5'd17:   b = 8'h20;
      5'd18:   b = 8'h08;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/cle_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_if: channel interfaces of the console line editor
// Receive byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       last_of_run;
  modport source (output valid, output out_byte, output out_kind, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input out_kind, input last_of_run,
                output ready);
endinterface

interface cle_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] line_size;
  modport source (output valid, output line_size, input ready);
  modport sink (input valid, input line_size, output ready);
endinterface

// ===== sv/cle_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_front: receive side of the console line editor
// Classifies each received byte and holds it in a two-word command queue.
// ----------------------------------------------------------------------------
module cle_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output cle_pkg::cmd_item_t  q_item
);

  cle_pkg::cmd_item_t q_mem_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               push, pop;
  cle_pkg::cmd_item_t item_new;

  // classify the received byte
  always_comb begin
    item_new.data = in_data;
    case (in_data)
      cle_pkg::CH_CR, cle_pkg::CH_LF: item_new.cmd = cle_pkg::CMD_EOL;
      cle_pkg::CH_DEL:                item_new.cmd = cle_pkg::CMD_DEL;
      cle_pkg::CH_FF:                 item_new.cmd = cle_pkg::CMD_FF;
      default:                        item_new.cmd = cle_pkg::CMD_APPEND;
    endcase
  end

  // queue handshakes
  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_new;
    end
  end

endmodule

// ===== sv/cle_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_back: execution side of the console line editor
// Sequencer that owns the line store and fill count and emits result words.
// ----------------------------------------------------------------------------
module cle_back #(
  parameter int LINE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [5:0]         line_size,
  input  logic               q_valid,
  output logic               q_ready,
  input  cle_pkg::cmd_item_t q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_kind,
  output logic               last_of_run
);

  localparam int IDX_W = (LINE_DEPTH > 2) ? $clog2(LINE_DEPTH) : 1;

  cle_pkg::back_state_t state_r, state_nxt;
  cle_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic [IDX_W-1:0]     fill_r, fill_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [4:0]           seq_r, seq_nxt;
  logic [7:0]           line_mem [LINE_DEPTH];
  logic [7:0]           rd_data_r;
  logic                 wr_en;

  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic [1:0]           out_kind_r;
  logic                 out_last_r;

  logic                 emit, emit_ok;
  logic [7:0]           emit_byte;
  logic [1:0]           emit_kind;
  logic                 emit_last;

  logic [6:0]           size_m1;
  logic [IDX_W-1:0]     cap;
  logic                 seq_end;
  logic                 cont_end;
  logic [4:0]           seq_last;

  // usable capacity from the line size register, saturated to the store
  always_comb begin
    size_m1 = {1'b0, line_size} - 7'd1;
    if (line_size == 6'd0) begin
      cap = '0;
    end else if (size_m1 > 7'(LINE_DEPTH - 1)) begin
      cap = IDX_W'(LINE_DEPTH - 1);
    end else begin
      cap = size_m1[IDX_W-1:0];
    end
  end

  // end of the echo sequence of the current command
  always_comb begin
    case (cmd_r)
      cle_pkg::CMD_FF:  seq_last = cle_pkg::SEQ_FF_LAST;
      cle_pkg::CMD_EOL: seq_last = cle_pkg::SEQ_EOL_LAST;
      default:          seq_last = cle_pkg::SEQ_DEL_LAST;
    endcase
  end

  assign emit_ok  = !out_valid_r || out_ready;
  assign seq_end  = (seq_r == seq_last);
  assign cont_end = (idx_r == fill_r - 1'b1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cle_pkg::BS_IDLE: begin
        if (q_valid) begin
          case (q_item.cmd)
            cle_pkg::CMD_EOL:
              state_nxt = (fill_r == '0) ? cle_pkg::BS_MARK : cle_pkg::BS_CONT;
            cle_pkg::CMD_FF:
              state_nxt = cle_pkg::BS_SEQ;
            cle_pkg::CMD_DEL:
              state_nxt = (fill_r != '0) ? cle_pkg::BS_SEQ : cle_pkg::BS_IDLE;
            default:
              state_nxt = (fill_r < cap) ? cle_pkg::BS_APP : cle_pkg::BS_IDLE;
          endcase
        end
      end
      cle_pkg::BS_APP: begin
        if (emit_ok) state_nxt = cle_pkg::BS_IDLE;
      end
      cle_pkg::BS_CONT: begin
        if (emit_ok && cont_end) begin
          state_nxt = (cmd_r == cle_pkg::CMD_EOL) ? cle_pkg::BS_MARK : cle_pkg::BS_IDLE;
        end
      end
      cle_pkg::BS_MARK: begin
        if (emit_ok) state_nxt = cle_pkg::BS_SEQ;
      end
      cle_pkg::BS_SEQ: begin
        if (emit_ok && seq_end) begin
          state_nxt = (cmd_r == cle_pkg::CMD_FF && fill_r != '0) ?
                      cle_pkg::BS_CONT : cle_pkg::BS_IDLE;
        end
      end
      default: state_nxt = cle_pkg::BS_IDLE;
    endcase
  end

  // datapath and emit controls per state
  always_comb begin
    q_ready   = 1'b0;
    emit      = 1'b0;
    emit_byte = byte_r;
    emit_kind = cle_pkg::KIND_ECHO;
    emit_last = 1'b0;
    wr_en     = 1'b0;
    cmd_nxt   = cmd_r;
    byte_nxt  = byte_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    seq_nxt   = seq_r;
    case (state_r)
      cle_pkg::BS_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_nxt  = q_item.cmd;
          byte_nxt = q_item.data;
          idx_nxt  = '0;
          case (q_item.cmd)
            cle_pkg::CMD_EOL: seq_nxt = cle_pkg::SEQ_EOL_FIRST;
            cle_pkg::CMD_FF:  seq_nxt = cle_pkg::SEQ_FF_FIRST;
            default:          seq_nxt = cle_pkg::SEQ_DEL_FIRST;
          endcase
          // rubout drops the last byte at once, its echo reads no content
          if (q_item.cmd == cle_pkg::CMD_DEL && fill_r != '0) begin
            fill_nxt = fill_r - 1'b1;
          end
        end
      end
      cle_pkg::BS_APP: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        if (emit_ok) begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      cle_pkg::BS_CONT: begin
        emit      = 1'b1;
        emit_byte = rd_data_r;
        emit_kind = (cmd_r == cle_pkg::CMD_EOL) ? cle_pkg::KIND_CONTENT : cle_pkg::KIND_ECHO;
        emit_last = (cmd_r == cle_pkg::CMD_FF) && cont_end;
        if (emit_ok) idx_nxt = idx_r + 1'b1;
      end
      cle_pkg::BS_MARK: begin
        emit      = 1'b1;
        emit_byte = 8'(fill_r);
        emit_kind = cle_pkg::KIND_MARK;
        if (emit_ok) fill_nxt = '0;
      end
      cle_pkg::BS_SEQ: begin
        emit      = 1'b1;
        emit_byte = cle_pkg::seq_byte(seq_r);
        emit_last = seq_end && !(cmd_r == cle_pkg::CMD_FF && fill_r != '0);
        if (emit_ok) begin
          seq_nxt = seq_r + 5'd1;
          if (seq_end) idx_nxt = '0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cle_pkg::BS_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (emit && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    byte_r <= byte_nxt;
    idx_r  <= idx_nxt;
    seq_r  <= seq_nxt;
    if (emit && emit_ok) begin
      out_byte_r <= emit_byte;
      out_kind_r <= emit_kind;
      out_last_r <= emit_last;
    end
  end

  // line store, read data follows the next content index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[fill_r] <= byte_r;
    end
    rd_data_r <= line_mem[idx_nxt];
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_kind    = out_kind_r;
  assign last_of_run = out_last_r;

endmodule

// ===== sv/console_line_editor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor_top: console line editor
// Canonical line discipline: echo, rubout, redraw and line hand-off.
// ----------------------------------------------------------------------------
// Received bytes are classified and queued (two words deep), then carried out
// one at a time by a sequencer that emits one result word per cycle within a
// run, while the output is taken, into a single output register. An ordinary
// byte gives its echo, a rubout a three-byte rubout echo, a form feed the
// redraw sequence and the held bytes, and a line ending the held bytes, a
// length marker and the line end sequence. A dropped byte or a rubout on an
// empty line gives no result. The line size register is taken on every write
// and should change only while the editor is idle.
module console_line_editor_top #(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cle_in_if.sink     in_ch,
  cle_out_if.source  out_ch,
  cle_cfg_if.sink    cfg_ch
);

  logic               q_valid;
  logic               q_ready;
  cle_pkg::cmd_item_t q_item;
  logic [5:0]         line_size_r;

  // line size register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_size_r <= 6'd32;
    end else if (cfg_ch.valid) begin
      line_size_r <= cfg_ch.line_size;
    end
  end

  // classify and queue
  cle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.rx_byte),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // execute and emit
  cle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .line_size   (line_size_r),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .out_kind    (out_ch.out_kind),
    .last_of_run (out_ch.last_of_run)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the console line editor
// Feeds received console bytes through the input channel, rewrites the line
// size between phases and checks every echo, content and marker word against
// an in-bench line editor model. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int LINE_DEPTH  = 32;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE      = 16;   // cycles for queued dropped bytes to clear
  localparam int RAND_ITEMS  = 220;
  localparam int PHASE_ITEMS = 40;
  localparam int UNTYPED     = -1;
  localparam int DIR_ROWS    = 31;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_ESC = 8'h1B;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } editor_word_t;

  typedef enum int {
    ROW_BYTE,
    ROW_SIZE
  } row_op_t;

  typedef struct {
    row_op_t    op;
    logic [7:0] val;
    int         n_words;
    logic [7:0] first_byte;
    logic [1:0] first_kind;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cle_in_if  in_if ();
  cle_out_if out_if ();
  cle_cfg_if cfg_if ();

  console_line_editor_top #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // echo sequences sent on redraw and on line end
  logic [7:0] redraw_seq [10] = '{CH_ESC, 8'h5B, 8'h32, 8'h4A, CH_ESC, 8'h5B, 8'h3B,
                                  8'h48, 8'h3E, CH_SP};
  logic [7:0] newline_seq [6] = '{cle_pkg::CH_CR, cle_pkg::CH_LF, cle_pkg::CH_CR,
                                  cle_pkg::CH_LF, 8'h3E, CH_SP};

  // line editor state as seen by the bench
  logic [7:0]   line_buf [LINE_DEPTH];
  int           line_len;
  logic [5:0]   size_reg;
  editor_word_t pending_words [$];

  int  errors;
  int  bytes_sent;
  int  busy_items;
  int  words_checked;
  int  size_writes;
  bit  in_idle_en;
  bit  out_idle_en;
  int  out_hold;

  function automatic void flag(string what, int want, int got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
  endfunction

  function automatic int line_cap();
    int cap;
    cap = (size_reg == 0) ? 0 : int'(size_reg) - 1;
    if (cap > LINE_DEPTH - 1) cap = LINE_DEPTH - 1;
    return cap;
  endfunction

  // apply one received byte to the line, queue the words it causes
  function automatic int edit_line(input logic [7:0] ch, output logic [7:0] first_byte,
                                   output logic [1:0] first_kind);
    editor_word_t run [$];
    if (ch == cle_pkg::CH_CR || ch == cle_pkg::CH_LF) begin
      for (int i = 0; i < line_len; i++)
        run.push_back('{line_buf[i], cle_pkg::KIND_CONTENT, 1'b0});
      run.push_back('{8'(line_len), cle_pkg::KIND_MARK, 1'b0});
      foreach (newline_seq[i]) run.push_back('{newline_seq[i], cle_pkg::KIND_ECHO, 1'b0});
      line_len = 0;
    end else if (ch == cle_pkg::CH_DEL) begin
      if (line_len != 0) begin
        line_len--;
        run.push_back('{CH_BS, cle_pkg::KIND_ECHO, 1'b0});
        run.push_back('{CH_SP, cle_pkg::KIND_ECHO, 1'b0});
        run.push_back('{CH_BS, cle_pkg::KIND_ECHO, 1'b0});
      end
    end else if (ch == cle_pkg::CH_FF) begin
      foreach (redraw_seq[i]) run.push_back('{redraw_seq[i], cle_pkg::KIND_ECHO, 1'b0});
      for (int i = 0; i < line_len; i++)
        run.push_back('{line_buf[i], cle_pkg::KIND_ECHO, 1'b0});
    end else if (line_len < line_cap()) begin
      run.push_back('{ch, cle_pkg::KIND_ECHO, 1'b0});
      line_buf[line_len] = ch;
      line_len++;
    end
    first_byte = 8'h00;
    first_kind = cle_pkg::KIND_ECHO;
    if (run.size() > 0) begin
      run[run.size() - 1].last = 1'b1;
      first_byte = run[0].data;
      first_kind = run[0].kind;
    end
    foreach (run[i]) pending_words.push_back(run[i]);
    return run.size();
  endfunction

  // result side: stall at random after each word, then compare with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_if.valid && out_if.ready) out_hold = out_idle_en ? $urandom_range(0, 15) : 0;
      if (out_hold > 0) begin
        out_if.ready <= 1'b0;
        out_hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_words
    editor_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        flag("unexpected word", 0, out_if.out_byte);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_if.out_byte !== want.data) flag("out_byte", want.data, out_if.out_byte);
        if (out_if.out_kind !== want.kind) flag("out_kind", want.kind, out_if.out_kind);
        if (out_if.last_of_run !== want.last) flag("last_of_run", want.last, out_if.last_of_run);
      end
    end
  end

  // present one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b, output int n, output logic [7:0] fb,
                           output logic [1:0] fk);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    n = edit_line(b, fb, fk);
    bytes_sent++;
    if (n > 0) busy_items++;
  endtask

  task automatic key(input logic [7:0] b);
    int         n;
    logic [7:0] fb;
    logic [1:0] fk;
    send_byte(b, n, fb, fk);
  endtask

  // let every expected word drain before touching the line size
  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(input logic [5:0] v);
    cfg_if.valid     <= 1'b1;
    cfg_if.line_size <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    size_reg = v;
    size_writes++;
  endtask

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [5:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 6'd0;
      1:       return 6'd1;
      2:       return 6'd2;
      3:       return 6'd3;
      4:       return 6'd31;
      5:       return 6'd32;
      6:       return 6'd33;
      7:       return 6'd63;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  // directed rows: byte or size write, with the run typed in where obvious
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_BYTE, cle_pkg::CH_DEL, 0,       8'h00,  cle_pkg::KIND_ECHO},  // rubout on empty line
    '{ROW_BYTE, cle_pkg::CH_CR,  7,       8'h00,  cle_pkg::KIND_MARK},  // empty line after reset
    '{ROW_BYTE, 8'h00,           1,       8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, 8'hFF,           1,       8'hFF,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, 8'h61,           UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, cle_pkg::CH_FF,  13,      CH_ESC, cle_pkg::KIND_ECHO},  // redraw with three held
    '{ROW_BYTE, cle_pkg::CH_DEL, 3,       CH_BS,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, cle_pkg::CH_CR,  9,       8'h00,  cle_pkg::KIND_CONTENT},
    '{ROW_BYTE, cle_pkg::CH_LF,  7,       8'h00,  cle_pkg::KIND_MARK},  // lf of a crlf pair
    '{ROW_SIZE, 8'd2,            UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, 8'h41,           1,       8'h41,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, 8'h42,           0,       8'h00,  cle_pkg::KIND_ECHO},  // full, dropped
    '{ROW_BYTE, cle_pkg::CH_FF,  11,      CH_ESC, cle_pkg::KIND_ECHO},
    '{ROW_BYTE, cle_pkg::CH_CR,  8,       8'h41,  cle_pkg::KIND_CONTENT},
    '{ROW_SIZE, 8'd0,            UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, 8'h55,           0,       8'h00,  cle_pkg::KIND_ECHO},  // no capacity at size zero
    '{ROW_SIZE, 8'd1,            UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, 8'h20,           0,       8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_SIZE, 8'd4,            UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, 8'h78,           UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, 8'h79,           UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, 8'h7A,           UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, 8'h77,           0,       8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_SIZE, 8'd2,            UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},  // size now below the fill
    '{ROW_BYTE, 8'h71,           0,       8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, cle_pkg::CH_FF,  13,      CH_ESC, cle_pkg::KIND_ECHO},
    '{ROW_BYTE, cle_pkg::CH_DEL, 3,       CH_BS,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, cle_pkg::CH_CR,  UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},
    '{ROW_SIZE, 8'd63,           UNTYPED, 8'h00,  cle_pkg::KIND_ECHO},  // capacity saturates to depth minus one
    '{ROW_BYTE, 8'h80,           1,       8'h80,  cle_pkg::KIND_ECHO},
    '{ROW_BYTE, cle_pkg::CH_LF,  UNTYPED, 8'h00,  cle_pkg::KIND_ECHO}
  };

  initial begin : stimulus
    int         n;
    int         len;
    int         cap;
    int         phase_start;
    int         item_goal;
    logic [7:0] fb;
    logic [1:0] fk;
    logic [7:0] pick;

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.rx_byte    = 8'h00;
    cfg_if.valid     = 1'b0;
    cfg_if.line_size = 6'd0;
    errors           = 0;
    bytes_sent       = 0;
    busy_items       = 0;
    words_checked    = 0;
    size_writes      = 0;
    line_len         = 0;
    size_reg         = 6'd32;
    in_idle_en       = 1'b1;
    out_idle_en      = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_SIZE) begin
        quiesce();
        write_size(dir_rows[i].val[5:0]);
      end else begin
        send_byte(dir_rows[i].val, n, fb, fk);
        if (dir_rows[i].n_words != UNTYPED) begin
          if (n != dir_rows[i].n_words)
            flag("typed run length", dir_rows[i].n_words, n);
          else if (n > 0 && (fb != dir_rows[i].first_byte || fk != dir_rows[i].first_kind))
            flag("typed first word", {dir_rows[i].first_kind, dir_rows[i].first_byte},
                 {fk, fb});
        end
      end
    end

    // random phases: mostly typed lines, some noise, some lines left open
    item_goal = bytes_sent + RAND_ITEMS;
    while (bytes_sent < item_goal) begin
      quiesce();
      write_size(pick_size());
      in_idle_en  = $urandom_range(0, 2) != 0;
      out_idle_en = $urandom_range(0, 2) != 0;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS && bytes_sent < item_goal) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) key(8'($urandom_range(0, 255)));
        end else begin
          cap = line_cap();
          case ($urandom_range(0, 3))
            0, 1:    len = $urandom_range(0, cap);
            2:       len = cap + $urandom_range(0, 3);
            default: len = $urandom_range(0, 8);
          endcase
          for (int j = 0; j < len; j++) begin
            case ($urandom_range(0, 19))
              0:       pick = cle_pkg::CH_DEL;
              1:       pick = cle_pkg::CH_FF;
              default: pick = text_byte();
            endcase
            key(pick);
          end
          case ($urandom_range(0, 2))
            0: key(cle_pkg::CH_CR);
            1: key(cle_pkg::CH_LF);
            default: begin
              key(cle_pkg::CH_CR);
              key(cle_pkg::CH_LF);
            end
          endcase
        end
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) key(text_byte());
    end

    quiesce();
    $display("sent %0d bytes, %0d of them with output, across %0d line size settings",
             bytes_sent, busy_items, size_writes);
    $display("checked %0d words, %0d mismatches", words_checked, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cle_pkg.sv
sv/cle_if.sv
sv/cle_front.sv
sv/cle_back.sv
sv/console_line_editor_top.sv
dv/tb.sv
